@@ rtl/cll_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_pkg: shared types and helpers for the command-line lexer
// Token kinds, transfer payloads, the token bundle and character classes.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int unsigned MaxLineLenDef = 4096;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned PosW          = 12;
  localparam int unsigned TokPerItem    = 3;

  typedef enum logic [3:0] {
    TOK_CONSTANT = 4'd0,
    TOK_STRING   = 4'd1,
    TOK_TEXT     = 4'd2,
    TOK_EQUAL    = 4'd3,
    TOK_COMMA    = 4'd4,
    TOK_OPEN     = 4'd5,
    TOK_CLOSE    = 4'd6,
    TOK_END      = 4'd7,
    TOK_INVALID  = 4'd8
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       no_char;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    tok_kind_e       token_kind;
    logic [PosW-1:0] tok_start;
    logic [PosW-1:0] tok_end;
    logic            line_done;
  } out_item_t;

  // Tokens raised by one input item, slot 0 first
  typedef struct packed {
    logic [1:0]                 cnt;
    out_item_t [TokPerItem-1:0] toks;
  } bundle_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChEqual  = 8'h3d;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f) || (c == ChMinus) ||
           (c == ChPlus) || (c == 8'h7e) || (c == 8'h2e) || (c == 8'h2f) ||
           (c == 8'h27);
  endfunction

  function automatic out_item_t make_tok(input tok_kind_e k, input logic [PosW-1:0] s,
                                         input logic [PosW-1:0] e, input logic d);
    out_item_t t;
    t.token_kind = k;
    t.tok_start  = s;
    t.tok_end    = e;
    t.line_done  = d;
    return t;
  endfunction

endpackage

@@ rtl/command_line_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_lexer: command-line tokeniser
// One line character in per transfer, typed tokens with offsets out.
// ----------------------------------------------------------------------------
// The lexer takes one character per cycle while the queue is not full and gives
// one token per cycle while the output is not stalled. An item usually raises
// zero or one token; a character that ends a word and is itself punctuation, on
// the last item of a line, raises up to three, which leave as separate transfers.
// A queue of QueueDepth token bundles sits between the scanner and the output
// register, so input stalls only once the queue is full. Offsets saturate at the smaller of MaxLineLen - 1 and 4095.
module command_line_lexer import cll_pkg::*; #(
  parameter int unsigned MaxLineLen = MaxLineLenDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  bundle_t bundle, head;
  logic    push, pop, full, empty, accept;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  cll_front #(.MaxLineLen(MaxLineLen)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .bundle_o (bundle)
  );

  cll_queue #(.QueueDepth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (bundle),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  cll_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o)
  );

endmodule

@@ rtl/cll_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_front: lexer state and classification
// Updates the scan mode per character and raises up to three tokens per item.
// ----------------------------------------------------------------------------
module cll_front import cll_pkg::*; #(
  parameter int unsigned MaxLineLen = MaxLineLenDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     push_o,
  output bundle_t  bundle_o
);

  localparam int unsigned PosMaxInt = (MaxLineLen - 1 < 4095) ? MaxLineLen - 1 : 4095;
  localparam logic [PosW-1:0] PosMax = PosW'(PosMaxInt);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_SIGN  = 3'd2,
    M_QUOTE = 3'd3,
    M_ESC   = 3'd4,
    M_DEAD  = 3'd5
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d, tb_q, tb_d, pe_q, pe_d;
  logic            nw_q, nw_d;
  bundle_t         bundle;

  always_comb begin
    logic [PosW-1:0] p, e;
    logic [1:0]      n;
    logic            do_idle;
    logic [7:0]      c;
    mode_d  = mode_q;
    pos_d   = pos_q;
    tb_d    = tb_q;
    pe_d    = pe_q;
    nw_d    = nw_q;
    bundle  = '0;
    n       = 2'd0;
    do_idle = 1'b0;
    c       = item_i.ch;
    p       = pos_q;
    e       = (pos_q >= PosMax) ? PosMax : pos_q + 1'b1;
    if (!item_i.no_char) begin
      case (mode_q)
        M_IDLE: begin
          do_idle = 1'b1;
        end
        M_WORD, M_SIGN: begin
          if (is_word(c)) begin
            if (mode_q == M_SIGN && is_digit(c)) nw_d = 1'b1;
            mode_d = M_WORD;
          end else begin
            bundle.toks[n] = make_tok(nw_q ? TOK_CONSTANT : TOK_STRING, tb_q, p, 1'b0);
            n       = n + 2'd1;
            pe_d    = p;
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_QUOTE: begin
          if (c == ChQuote) begin
            bundle.toks[n] = make_tok(TOK_TEXT, tb_q, e, 1'b0);
            n      = n + 2'd1;
            pe_d   = e;
            mode_d = M_IDLE;
          end else if (c == ChBslash) begin
            mode_d = M_ESC;
          end
        end
        M_ESC: begin
          mode_d = M_QUOTE;
        end
        default: begin
        end
      endcase
      if (do_idle) begin
        if (is_blank(c)) begin
        end else if (c == ChEqual || c == ChComma || c == ChOpen || c == ChClose) begin
          bundle.toks[n] = make_tok((c == ChEqual) ? TOK_EQUAL :
                                    (c == ChComma) ? TOK_COMMA :
                                    (c == ChOpen)  ? TOK_OPEN : TOK_CLOSE, p, e, 1'b0);
          n    = n + 2'd1;
          pe_d = e;
        end else if (c == ChQuote) begin
          tb_d   = p;
          mode_d = M_QUOTE;
        end else if (!is_word(c)) begin
          bundle.toks[n] = make_tok(TOK_INVALID, p, e, 1'b1);
          n      = n + 2'd1;
          pe_d   = e;
          mode_d = M_DEAD;
        end else begin
          tb_d   = p;
          nw_d   = is_digit(c);
          mode_d = (c == ChPlus || c == ChMinus) ? M_SIGN : M_WORD;
        end
      end
      pos_d = e;
    end
    if (item_i.line_last) begin
      case (mode_d)
        M_WORD, M_SIGN: begin
          bundle.toks[n] = make_tok(nw_d ? TOK_CONSTANT : TOK_STRING, tb_d, pos_d, 1'b0);
          n = n + 2'd1;
          bundle.toks[n] = make_tok(TOK_END, pos_d, pos_d, 1'b1);
          n = n + 2'd1;
        end
        M_QUOTE, M_ESC: begin
          bundle.toks[n] = make_tok(TOK_INVALID, tb_d, pos_d, 1'b1);
          n = n + 2'd1;
        end
        M_IDLE: begin
          bundle.toks[n] = make_tok(TOK_END, pe_d, pe_d, 1'b1);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      mode_d = M_IDLE;
      pos_d  = '0;
      tb_d   = '0;
      pe_d   = '0;
      nw_d   = 1'b0;
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      tb_q   <= '0;
      pe_q   <= '0;
      nw_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      tb_q   <= tb_d;
      pe_q   <= pe_d;
      nw_q   <= nw_d;
    end
  end

  assign push_o   = accept_i && (bundle.cnt != 2'd0);
  assign bundle_o = bundle;

endmodule

@@ rtl/cll_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_queue: token bundle queue
// Short first-in first-out store between front and back.
// ----------------------------------------------------------------------------
module cll_queue import cll_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  bundle_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign head_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);

endmodule

@@ rtl/cll_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_back: token output stage
// Unpacks queued bundles into single-token transfers behind an output register.
// ----------------------------------------------------------------------------
module cll_back import cll_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      valid_o,
  input  logic      stall_i,
  output out_item_t item_o
);

  logic [1:0] sel_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       load, last_sel;

  assign last_sel = (sel_q == head_i.cnt - 2'd1);
  assign load     = !empty_i && (!out_valid_q || !stall_i);
  assign pop_o    = load && last_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      sel_q       <= last_sel ? 2'd0 : sel_q + 2'd1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= head_i.toks[sel_q];
  end

  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

@@ rtl/cll_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_checker: port-level checks for the command-line lexer
// Watches the token channel and is bound to the top level.
// ----------------------------------------------------------------------------
module cll_checker import cll_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled token changed");

  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.line_done == (out_item_o.token_kind == TOK_END ||
                                             out_item_o.token_kind == TOK_INVALID))
    else $error("line_done on wrong token kind");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.token_kind == TOK_END |->
      out_item_o.tok_start == out_item_o.tok_end)
    else $error("end token not empty");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.tok_start <= out_item_o.tok_end)
    else $error("token start past end");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.token_kind <= TOK_INVALID)
    else $error("token kind out of range");

endmodule

bind command_line_lexer cll_checker u_cll_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ verif/tb_command_line_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_line_lexer: self-checking bench for the command-line lexer
// A directed table followed by random lines is fed one character per transfer.
// A token model in the bench predicts every token; each output transfer is
// checked field by field. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_command_line_lexer;
  import cll_pkg::*;

  localparam int unsigned     ItemTarget = 480;
  localparam int unsigned     CalmItems  = 60;
  localparam int unsigned     CycleLimit = 1000000;
  localparam int unsigned     DrainCycles = 32;
  localparam logic [PosW-1:0] PosMax     =
    (MaxLineLenDef - 1 < 4095) ? PosW'(MaxLineLenDef - 1) : 12'd4095;
  localparam out_item_t       NoTok      = '0;

  typedef enum logic [2:0] {
    LM_IDLE, LM_WORD, LM_SIGN, LM_QUOTE, LM_ESC, LM_DEAD
  } lex_mode_e;

  // directed row: optionally carries the tokens it must raise
  typedef struct packed {
    in_item_t        item;
    logic            pinned;
    logic [1:0]      n_tok;
    out_item_t [2:0] tok;
  } lex_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bit          idle_en    = 1'b1;
  int unsigned n_mismatch = 0;
  int unsigned n_cycles   = 0;
  int unsigned n_sent     = 0;
  int unsigned n_new;

  out_item_t   pending_tokens[$];
  out_item_t   tok_want;
  lex_row_t    dir_rows[$];
  logic [7:0]  line_buf[$];

  lex_mode_e       lx_mode;
  logic [PosW-1:0] lx_pos;
  logic [PosW-1:0] lx_begin;
  logic            lx_numeric;
  logic [PosW-1:0] lx_prev_end;

  command_line_lexer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- token model
  function automatic logic digit_ch(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic word_ch(input logic [7:0] c);
    if (digit_ch(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")))
      return 1'b1;
    case (c)
      "_", ChMinus, ChPlus, "~", ".", "/", "'": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [PosW-1:0] pos_inc(input logic [PosW-1:0] v);
    return (v >= PosMax) ? PosMax : v + 1'b1;
  endfunction

  function automatic void clear_line();
    lx_mode     = LM_IDLE;
    lx_pos      = '0;
    lx_begin    = '0;
    lx_numeric  = 1'b0;
    lx_prev_end = '0;
  endfunction

  function automatic void emit_tok(input tok_kind_e k, input logic [PosW-1:0] s,
                                   input logic [PosW-1:0] e, input logic d);
    out_item_t t;
    t.token_kind = k;
    t.tok_start  = s;
    t.tok_end    = e;
    t.line_done  = d;
    pending_tokens.push_back(t);
    lx_prev_end = e;
    n_new++;
  endfunction

  function automatic void start_token(input logic [7:0] c, input logic [PosW-1:0] p);
    logic [PosW-1:0] e;
    e = pos_inc(p);
    if (blank_ch(c)) return;
    if (c == ChEqual) emit_tok(TOK_EQUAL, p, e, 1'b0);
    else if (c == ChComma) emit_tok(TOK_COMMA, p, e, 1'b0);
    else if (c == ChOpen) emit_tok(TOK_OPEN, p, e, 1'b0);
    else if (c == ChClose) emit_tok(TOK_CLOSE, p, e, 1'b0);
    else if (c == ChQuote) begin
      lx_begin = p;
      lx_mode  = LM_QUOTE;
    end else if (!word_ch(c)) begin
      emit_tok(TOK_INVALID, p, e, 1'b1);
      lx_mode = LM_DEAD;
    end else begin
      lx_begin   = p;
      lx_numeric = digit_ch(c);
      lx_mode    = ((c == ChPlus) || (c == ChMinus)) ? LM_SIGN : LM_WORD;
    end
  endfunction

  // returns the number of tokens the transfer raises
  function automatic int unsigned tokenise_item(input in_item_t it);
    logic [PosW-1:0] p;
    logic [PosW-1:0] e;
    n_new = 0;
    if (!it.no_char) begin
      p = lx_pos;
      e = pos_inc(p);
      case (lx_mode)
        LM_IDLE: start_token(it.ch, p);
        LM_WORD, LM_SIGN: begin
          if (word_ch(it.ch)) begin
            if ((lx_mode == LM_SIGN) && digit_ch(it.ch)) lx_numeric = 1'b1;
            lx_mode = LM_WORD;
          end else begin
            emit_tok(lx_numeric ? TOK_CONSTANT : TOK_STRING, lx_begin, p, 1'b0);
            lx_mode = LM_IDLE;
            start_token(it.ch, p);
          end
        end
        LM_QUOTE: begin
          if (it.ch == ChQuote) begin
            emit_tok(TOK_TEXT, lx_begin, e, 1'b0);
            lx_mode = LM_IDLE;
          end else if (it.ch == ChBslash) begin
            lx_mode = LM_ESC;
          end
        end
        LM_ESC: lx_mode = LM_QUOTE;
        default: ;
      endcase
      lx_pos = e;
    end
    if (it.line_last) begin
      case (lx_mode)
        LM_WORD, LM_SIGN: begin
          emit_tok(lx_numeric ? TOK_CONSTANT : TOK_STRING, lx_begin, lx_pos, 1'b0);
          emit_tok(TOK_END, lx_prev_end, lx_prev_end, 1'b1);
        end
        LM_QUOTE, LM_ESC: emit_tok(TOK_INVALID, lx_begin, lx_pos, 1'b1);
        LM_IDLE: emit_tok(TOK_END, lx_prev_end, lx_prev_end, 1'b1);
        default: ;
      endcase
      clear_line();
    end
    return n_new;
  endfunction

  // ------------------------------------------------------------ directed table
  function automatic out_item_t tok_of(input tok_kind_e k, input int unsigned s,
                                       input int unsigned e, input logic d);
    out_item_t t;
    t.token_kind = k;
    t.tok_start  = PosW'(s);
    t.tok_end    = PosW'(e);
    t.line_done  = d;
    return t;
  endfunction

  function automatic void pred_row(input logic [7:0] c, input logic nc, input logic last);
    lex_row_t r;
    r = '0;
    r.item.ch        = c;
    r.item.no_char   = nc;
    r.item.line_last = last;
    dir_rows.push_back(r);
  endfunction

  function automatic void pin_row(input logic [7:0] c, input logic nc, input logic last,
                                  input logic [1:0] n, input out_item_t t0,
                                  input out_item_t t1, input out_item_t t2);
    lex_row_t r;
    r.item.ch        = c;
    r.item.no_char   = nc;
    r.item.line_last = last;
    r.pinned         = 1'b1;
    r.n_tok          = n;
    r.tok[0]         = t0;
    r.tok[1]         = t1;
    r.tok[2]         = t2;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------- random lines
  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return 8'h09;
      2: return 8'h0a;
      default: return 8'h0d;
    endcase
  endfunction

  function automatic logic [7:0] rand_word_ch();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
      3: return 8'h41 + 8'($urandom_range(0, 25));
      4, 5: return 8'h30 + 8'($urandom_range(0, 9));
      6: return ChPlus;
      7: return "_";
      8: return "~";
      default: begin
        case ($urandom_range(0, 3))
          0: return ".";
          1: return "/";
          2: return "'";
          default: return ChMinus;
        endcase
      end
    endcase
  endfunction

  function automatic void add_tokens(input int unsigned n_tok);
    for (int t = 0; t < n_tok; t++) begin
      repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          line_buf.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) +
                             8'($urandom_range(0, 25)));
          repeat ($urandom_range(0, 5)) line_buf.push_back(rand_word_ch());
        end
        3, 4: begin
          if ($urandom_range(0, 1)) line_buf.push_back($urandom_range(0, 1) ? ChPlus : ChMinus);
          line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
          repeat ($urandom_range(0, 4)) line_buf.push_back(rand_word_ch());
        end
        5: begin
          line_buf.push_back($urandom_range(0, 1) ? ChPlus : ChMinus);
          repeat ($urandom_range(0, 2)) line_buf.push_back(rand_word_ch());
        end
        6, 7: begin
          line_buf.push_back(ChQuote);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
              0: begin
                line_buf.push_back(ChBslash);
                line_buf.push_back(8'($urandom));
              end
              1: line_buf.push_back(8'($urandom));
              2: line_buf.push_back(rand_blank());
              default: line_buf.push_back(rand_word_ch());
            endcase
          end
          if ($urandom_range(0, 5) != 0) line_buf.push_back(ChQuote);
        end
        8, 9: begin
          case ($urandom_range(0, 3))
            0: line_buf.push_back(ChEqual);
            1: line_buf.push_back(ChComma);
            2: line_buf.push_back(ChOpen);
            default: line_buf.push_back(ChClose);
          endcase
        end
        10: line_buf.push_back(8'($urandom));
        default: repeat ($urandom_range(1, 6)) line_buf.push_back(rand_word_ch());
      endcase
    end
  endfunction

  // ------------------------------------------------------------------ driving
  task automatic send_item(input in_item_t it, output int unsigned n_pred);
    if (idle_en && ($urandom_range(0, 5) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_pred = tokenise_item(it);
    @(negedge clk);
  endtask

  task automatic send_line(input bit counted);
    in_item_t    it;
    bit          tail;
    int unsigned n_pred;
    tail = (line_buf.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (line_buf[i]) begin
      if ($urandom_range(0, 15) == 0) begin
        it.ch        = 8'($urandom);
        it.no_char   = 1'b1;
        it.line_last = 1'b0;
        send_item(it, n_pred);
        if (counted) n_sent++;
      end
      it.ch        = line_buf[i];
      it.no_char   = 1'b0;
      it.line_last = !tail && (i == line_buf.size() - 1);
      send_item(it, n_pred);
      if (counted) n_sent++;
    end
    if (tail) begin
      it.ch        = 8'($urandom);
      it.no_char   = 1'b1;
      it.line_last = 1'b1;
      send_item(it, n_pred);
      if (counted) n_sent++;
    end
  endtask

  always begin
    @(negedge clk);
    if (idle_en && ($urandom_range(0, 7) == 0)) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    out_stall <= 1'b0;
  end

  // ----------------------------------------------------------------- checking
  function automatic void report_field(input string name, input int unsigned want,
                                       input int unsigned got);
    n_mismatch++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        n_mismatch++;
        $display("%0t ns: token with none expected, got kind %0d start %0d end %0d done %0b",
                 $time, out_item.token_kind, out_item.tok_start, out_item.tok_end,
                 out_item.line_done);
      end else begin
        tok_want = pending_tokens.pop_front();
        if (out_item.token_kind !== tok_want.token_kind)
          report_field("token_kind", tok_want.token_kind, out_item.token_kind);
        if (out_item.tok_start !== tok_want.tok_start)
          report_field("tok_start", tok_want.tok_start, out_item.tok_start);
        if (out_item.tok_end !== tok_want.tok_end)
          report_field("tok_end", tok_want.tok_end, out_item.tok_end);
        if (out_item.line_done !== tok_want.line_done)
          report_field("line_done", tok_want.line_done, out_item.line_done);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stim
    int unsigned n_pred;
    clear_line();

    // single Equal, End at its end offset
    pin_row(ChEqual, 1'b0, 1'b1, 2'd2, tok_of(TOK_EQUAL, 0, 1, 1'b0),
            tok_of(TOK_END, 1, 1, 1'b1), NoTok);
    // empty transfer without line end is ignored; empty line gives End at zero
    pin_row(8'hff, 1'b1, 1'b0, 2'd0, NoTok, NoTok, NoTok);
    pin_row(8'h00, 1'b1, 1'b1, 2'd1, tok_of(TOK_END, 0, 0, 1'b1), NoTok, NoTok);
    // signed constant ended by punctuation on the line's last character
    pin_row(ChMinus, 1'b0, 1'b0, 2'd0, NoTok, NoTok, NoTok);
    pin_row("5", 1'b0, 1'b0, 2'd0, NoTok, NoTok, NoTok);
    pin_row(ChComma, 1'b0, 1'b1, 2'd3, tok_of(TOK_CONSTANT, 0, 2, 1'b0),
            tok_of(TOK_COMMA, 2, 3, 1'b0), tok_of(TOK_END, 3, 3, 1'b1));
    // lone sign is a String
    pin_row(ChPlus, 1'b0, 1'b1, 2'd2, tok_of(TOK_STRING, 0, 1, 1'b0),
            tok_of(TOK_END, 1, 1, 1'b1), NoTok);
    // quote left open, closing quote escaped
    pin_row(ChQuote, 1'b0, 1'b0, 2'd0, NoTok, NoTok, NoTok);
    pin_row(ChBslash, 1'b0, 1'b0, 2'd0, NoTok, NoTok, NoTok);
    pin_row(ChQuote, 1'b0, 1'b1, 2'd1, tok_of(TOK_INVALID, 0, 3, 1'b1), NoTok, NoTok);
    pred_row(ChQuote, 1'b0, 1'b0);
    pred_row("x", 1'b0, 1'b0);
    pred_row(ChQuote, 1'b0, 1'b0);
    pred_row(ChClose, 1'b0, 1'b1);
    // stray invalid character ends the line; the rest is ignored
    pin_row("#", 1'b0, 1'b0, 2'd1, tok_of(TOK_INVALID, 0, 1, 1'b1), NoTok, NoTok);
    pin_row("a", 1'b0, 1'b0, 2'd0, NoTok, NoTok, NoTok);
    pin_row(8'hff, 1'b0, 1'b1, 2'd0, NoTok, NoTok, NoTok);
    pin_row(8'h00, 1'b0, 1'b1, 2'd1, tok_of(TOK_INVALID, 0, 1, 1'b1), NoTok, NoTok);
    pred_row(8'h09, 1'b0, 1'b0);
    pred_row("a", 1'b0, 1'b0);
    pred_row(ChMinus, 1'b0, 1'b0);
    pred_row(8'h0d, 1'b0, 1'b0);
    pred_row("7", 1'b0, 1'b0);
    pred_row(ChOpen, 1'b0, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, n_pred);
      if (dir_rows[i].pinned) begin
        repeat (n_pred) pending_tokens.delete(pending_tokens.size() - 1);
        for (int k = 0; k < dir_rows[i].n_tok; k++)
          pending_tokens.push_back(dir_rows[i].tok[k]);
      end
    end

    while (n_sent < ItemTarget) begin
      idle_en = (n_sent < ItemTarget - CalmItems);
      line_buf.delete();
      if ($urandom_range(0, 19) != 0) add_tokens($urandom_range(1, 6));
      send_line(1'b1);
    end

    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
